@@ design/cbt_pkg.sv @@
package cbt_pkg;

    localparam int MAX_POINTS = 64;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 6;
    localparam int T_W        = 17;
    localparam int REM_W      = 7;
    localparam int COORD_W    = 32;
    localparam int W_W        = 31;
    localparam int B_W        = 49;
    localparam int ACC_W      = 64;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    // control points, index 0 start, 1 ctrl1, 2 ctrl2, 3 end
    typedef struct packed {
        logic [3:0][COORD_W-1:0] x;
        logic [3:0][COORD_W-1:0] y;
    } t_seg;

    // t step per point for a divisor d = N-1: 131072 / 2d = 65536 / d,
    // remainder 2 * (65536 mod d)
    localparam logic [T_W-1:0] STEP_Q [MAX_POINTS] = '{
        17'd0,
        17'(65536/1),  17'(65536/2),  17'(65536/3),  17'(65536/4),  17'(65536/5),
        17'(65536/6),  17'(65536/7),  17'(65536/8),  17'(65536/9),  17'(65536/10),
        17'(65536/11), 17'(65536/12), 17'(65536/13), 17'(65536/14), 17'(65536/15),
        17'(65536/16), 17'(65536/17), 17'(65536/18), 17'(65536/19), 17'(65536/20),
        17'(65536/21), 17'(65536/22), 17'(65536/23), 17'(65536/24), 17'(65536/25),
        17'(65536/26), 17'(65536/27), 17'(65536/28), 17'(65536/29), 17'(65536/30),
        17'(65536/31), 17'(65536/32), 17'(65536/33), 17'(65536/34), 17'(65536/35),
        17'(65536/36), 17'(65536/37), 17'(65536/38), 17'(65536/39), 17'(65536/40),
        17'(65536/41), 17'(65536/42), 17'(65536/43), 17'(65536/44), 17'(65536/45),
        17'(65536/46), 17'(65536/47), 17'(65536/48), 17'(65536/49), 17'(65536/50),
        17'(65536/51), 17'(65536/52), 17'(65536/53), 17'(65536/54), 17'(65536/55),
        17'(65536/56), 17'(65536/57), 17'(65536/58), 17'(65536/59), 17'(65536/60),
        17'(65536/61), 17'(65536/62), 17'(65536/63)
    };

    localparam logic [REM_W-1:0] STEP_R [MAX_POINTS] = '{
        7'd0,
        7'(2*(65536%1)),  7'(2*(65536%2)),  7'(2*(65536%3)),  7'(2*(65536%4)),
        7'(2*(65536%5)),  7'(2*(65536%6)),  7'(2*(65536%7)),  7'(2*(65536%8)),
        7'(2*(65536%9)),  7'(2*(65536%10)), 7'(2*(65536%11)), 7'(2*(65536%12)),
        7'(2*(65536%13)), 7'(2*(65536%14)), 7'(2*(65536%15)), 7'(2*(65536%16)),
        7'(2*(65536%17)), 7'(2*(65536%18)), 7'(2*(65536%19)), 7'(2*(65536%20)),
        7'(2*(65536%21)), 7'(2*(65536%22)), 7'(2*(65536%23)), 7'(2*(65536%24)),
        7'(2*(65536%25)), 7'(2*(65536%26)), 7'(2*(65536%27)), 7'(2*(65536%28)),
        7'(2*(65536%29)), 7'(2*(65536%30)), 7'(2*(65536%31)), 7'(2*(65536%32)),
        7'(2*(65536%33)), 7'(2*(65536%34)), 7'(2*(65536%35)), 7'(2*(65536%36)),
        7'(2*(65536%37)), 7'(2*(65536%38)), 7'(2*(65536%39)), 7'(2*(65536%40)),
        7'(2*(65536%41)), 7'(2*(65536%42)), 7'(2*(65536%43)), 7'(2*(65536%44)),
        7'(2*(65536%45)), 7'(2*(65536%46)), 7'(2*(65536%47)), 7'(2*(65536%48)),
        7'(2*(65536%49)), 7'(2*(65536%50)), 7'(2*(65536%51)), 7'(2*(65536%52)),
        7'(2*(65536%53)), 7'(2*(65536%54)), 7'(2*(65536%55)), 7'(2*(65536%56)),
        7'(2*(65536%57)), 7'(2*(65536%58)), 7'(2*(65536%59)), 7'(2*(65536%60)),
        7'(2*(65536%61)), 7'(2*(65536%62)), 7'(2*(65536%63))
    };

endpackage

@@ design/cbt_datapath.sv @@
module cbt_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  cbt_pkg::t_ctl                      i_ctl,
    input  logic [cbt_pkg::T_W-1:0]            i_t,
    input  cbt_pkg::t_seg                      i_seg,
    output cbt_pkg::t_ctl                      o_ctl,
    output logic signed [cbt_pkg::ACC_W-1:0]   o_acc_x,
    output logic signed [cbt_pkg::ACC_W-1:0]   o_acc_y
);

    localparam int SQ_W = 2 * cbt_pkg::T_W;

    logic [cbt_pkg::T_W-1:0] n_u;

    // stage 1: squares and cross term
    cbt_pkg::t_ctl           r1_ctl;
    cbt_pkg::t_seg           r1_seg;
    logic [cbt_pkg::T_W-1:0] r1_u, r1_t;
    logic [SQ_W-1:0]         r1_uu, r1_tt, r1_ut;
    // stage 2: cubic Bernstein terms in Q1.48
    cbt_pkg::t_ctl           r2_ctl;
    cbt_pkg::t_seg           r2_seg;
    logic [cbt_pkg::B_W-1:0] r2_b [4];
    // stage 3: weights in Q1.30
    cbt_pkg::t_ctl           r3_ctl;
    cbt_pkg::t_seg           r3_seg;
    logic [cbt_pkg::W_W-1:0] r3_w [4];
    // stage 4: weighted coordinates
    cbt_pkg::t_ctl                     r4_ctl;
    logic signed [cbt_pkg::ACC_W-1:0]  r4_px [4];
    logic signed [cbt_pkg::ACC_W-1:0]  r4_py [4];
    // stage 5: sums
    cbt_pkg::t_ctl                     r5_ctl;
    logic signed [cbt_pkg::ACC_W-1:0]  r5_ax, r5_ay;

    logic [SQ_W+cbt_pkg::T_W-1:0] n_uut, n_utt;

    assign n_u   = cbt_pkg::T_W'(17'd65536 - i_t);
    assign n_uut = r1_uu * r1_t;
    assign n_utt = r1_ut * r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else if (i_adv) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_seg <= i_seg;
            r1_u   <= n_u;
            r1_t   <= i_t;
            r1_uu  <= n_u * n_u;
            r1_tt  <= i_t * i_t;
            r1_ut  <= n_u * i_t;

            r2_seg  <= r1_seg;
            r2_b[0] <= cbt_pkg::B_W'(r1_uu * r1_u);
            r2_b[1] <= cbt_pkg::B_W'((n_uut << 1) + n_uut);
            r2_b[2] <= cbt_pkg::B_W'((n_utt << 1) + n_utt);
            r2_b[3] <= cbt_pkg::B_W'(r1_tt * r1_t);

            r3_seg <= r2_seg;
            for (int k = 0; k < 4; k++) begin
                r3_w[k] <= cbt_pkg::W_W'((r2_b[k] + 49'd131072) >> 18);
            end

            for (int k = 0; k < 4; k++) begin
                r4_px[k] <= $signed(r3_seg.x[k]) * $signed({1'b0, r3_w[k]});
                r4_py[k] <= $signed(r3_seg.y[k]) * $signed({1'b0, r3_w[k]});
            end

            r5_ax <= (r4_px[0] + r4_px[1]) + (r4_px[2] + r4_px[3]);
            r5_ay <= (r4_py[0] + r4_py[1]) + (r4_py[2] + r4_py[3]);
        end
    end

    assign o_ctl   = r5_ctl;
    assign o_acc_x = r5_ax;
    assign o_acc_y = r5_ay;

endmodule

@@ design/cubic_bezier_tessellator_unit.sv @@
// Points pass from the point sequencer through the datapath and output register.
// Throughput: one point per cycle unless the sink stalls the output; a segment
// yields N = points_per_segment points (clamped to 2..64), one t each from the sequencer.
// The next segment is taken in the cycle its predecessor's last t issues.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets N to 16.
module cubic_bezier_tessellator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config: points_per_segment
    input  logic         i_cfg_we,
    input  logic [6:0]   i_cfg_wdata,
    // segment in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] start_x, [63:32] start_y, [95:64] ctrl1_x, [127:96] ctrl1_y,
    // [159:128] ctrl2_x, [191:160] ctrl2_y, [223:192] end_x, [255:224] end_y
    input  logic [255:0] i_s_axis_tdata,
    // points out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] point_x, [63:32] point_y
    output logic [63:0]  o_m_axis_tdata,
    output logic         o_m_axis_tlast   // last_point
);

    // Configuration register
    logic [cbt_pkg::CNT_W-1:0] r_count;
    logic [cbt_pkg::IDX_W-1:0] n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= cbt_pkg::CNT_W'(16);
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // Divisor N-1 with N clamped to 2..MAX_POINTS
    always_comb begin
        priority if (r_count < cbt_pkg::CNT_W'(2)) begin
            n_den = cbt_pkg::IDX_W'(1);
        end else if (r_count > cbt_pkg::CNT_W'(cbt_pkg::MAX_POINTS)) begin
            n_den = cbt_pkg::IDX_W'(cbt_pkg::MAX_POINTS - 1);
        end else begin
            n_den = cbt_pkg::IDX_W'(r_count - cbt_pkg::CNT_W'(1));
        end
    end

    // The whole pipeline moves together; it stalls only when the output
    // register holds a point the sink has not taken.
    logic r_out_valid;
    logic adv;
    assign adv = !r_out_valid || i_m_axis_tready;

    // Point sequencer: t_i = round(i*65536/(N-1)) kept as quotient r_q and
    // remainder r_rem of (i*131072 + den) / (2*den), stepped incrementally.
    logic                        r_busy;
    logic [cbt_pkg::IDX_W-1:0]   r_i, r_den;
    logic [cbt_pkg::T_W-1:0]     r_q, r_stq;
    logic [cbt_pkg::REM_W-1:0]   r_rem, r_str;
    cbt_pkg::t_seg               r_seg;
    logic                        seq_last, issue, in_acc;
    logic [cbt_pkg::REM_W:0]     n_rsum, n_two_den;

    assign seq_last        = (r_i == r_den);
    assign issue           = r_busy && adv;
    assign o_s_axis_tready = adv && (!r_busy || seq_last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign n_rsum          = {1'b0, r_rem} + {1'b0, r_str};
    assign n_two_den       = {1'b0, r_den, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
        end else if (issue && seq_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_den <= n_den;
            r_stq <= cbt_pkg::STEP_Q[n_den];
            r_str <= cbt_pkg::STEP_R[n_den];
            r_i   <= '0;
            r_q   <= '0;
            r_rem <= cbt_pkg::REM_W'(n_den);
            for (int k = 0; k < 4; k++) begin
                r_seg.x[k] <= i_s_axis_tdata[64*k +: 32];
                r_seg.y[k] <= i_s_axis_tdata[64*k+32 +: 32];
            end
        end else if (issue) begin
            r_i <= r_i + cbt_pkg::IDX_W'(1);
            if (n_rsum >= n_two_den) begin
                r_rem <= cbt_pkg::REM_W'(n_rsum - n_two_den);
                r_q   <= r_q + r_stq + cbt_pkg::T_W'(1);
            end else begin
                r_rem <= cbt_pkg::REM_W'(n_rsum);
                r_q   <= r_q + r_stq;
            end
        end
    end

    // Evaluation pipeline
    cbt_pkg::t_ctl                    seq_ctl, dp_ctl;
    logic signed [cbt_pkg::ACC_W-1:0] acc_x, acc_y;

    assign seq_ctl.valid = r_busy;
    assign seq_ctl.last  = seq_last;

    cbt_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_ctl   (seq_ctl),
        .i_t     (r_q),
        .i_seg   (r_seg),
        .o_ctl   (dp_ctl),
        .o_acc_x (acc_x),
        .o_acc_y (acc_y)
    );

    // Round Q.42 half up to Q.12, then saturate to 32 bits
    function automatic logic [31:0] round_sat(input logic signed [63:0] acc);
        logic signed [63:0] biased;
        logic signed [33:0] sh;
        biased = acc + 64'sd536870912;
        sh     = 34'(biased >>> 30);
        if (sh > 34'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (sh < -34'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return sh[31:0];
        end
    endfunction

    logic [31:0] r_px, r_py;
    logic        r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= dp_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px   <= round_sat(acc_x);
            r_py   <= round_sat(acc_y);
            r_last <= dp_ctl.last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_py, r_px};
    assign o_m_axis_tlast  = r_last;

endmodule

@@ design/cbt_checker.sv @@
module cbt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [63:0]  o_m_axis_tdata,
    input logic         o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output payload changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input taken while pipeline stalled");

endmodule

bind cubic_bezier_tessellator_unit cbt_checker u_cbt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ tb/tb_cubic_bezier_tessellator_unit.sv @@
module tb_cubic_bezier_tessellator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_SEGS    = 240;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [6:0]   i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [255:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [63:0]  o_m_axis_tdata;
    logic         o_m_axis_tlast;

    cubic_bezier_tessellator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
    } t_point;

    // one directed row: segment coordinates, plus a known first point where the
    // answer is plain (t = 0 gives the start point exactly)
    typedef struct {
        logic [255:0] seg;
        logic         has_known;
        t_point       known;
    } t_seg_row;

    t_point      expected_points[$];
    logic [6:0]  count_reg = 7'd16;  // tracked points_per_segment
    int          n_fail = 0;
    int          idle_cycles = 0;
    bit          rx_quiet = 1'b0;    // no random stalls on the receiver side
    bit          rx_hold = 1'b0;     // receiver held off for a long stretch
    bit          tx_quiet = 1'b0;

    // clamp the register to the usable point count
    function automatic int points_used(input logic [6:0] r);
        if (r < 2) return 2;
        if (r > cbt_pkg::MAX_POINTS) return cbt_pkg::MAX_POINTS;
        return int'(r);
    endfunction

    // weighted sum in Q.42 rounded half up to Q.12, saturated to 32 bits
    function automatic logic [31:0] blend_coord(input logic [3:0][31:0] c,
                                                 input longint w[4]);
        logic signed [95:0] acc;
        logic signed [95:0] r;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += 96'(signed'(c[k])) * 96'(w[k]);
        r = (acc + 96'sd536870912) >>> 30;
        if (r > 96'sd2147483647) return 32'h7fffffff;
        if (r < -96'sd2147483648) return 32'h80000000;
        return r[31:0];
    endfunction

    task automatic predict_curve(input logic [255:0] seg);
        cbt_pkg::t_seg s;
        int     n;
        longint den, t, u;
        logic [63:0] b[4];
        longint w[4];
        t_point p;
        for (int k = 0; k < 4; k++) begin
            s.x[k] = seg[64*k +: 32];
            s.y[k] = seg[64*k + 32 +: 32];
        end
        n = points_used(count_reg);
        den = n - 1;
        for (int i = 0; i < n; i++) begin
            t = (longint'(i) * 131072 + den) / (2 * den);
            u = 65536 - t;
            b[0] = u * u * u;
            b[1] = 3 * u * u * t;
            b[2] = 3 * u * t * t;
            b[3] = t * t * t;
            for (int k = 0; k < 4; k++)
                w[k] = longint'((b[k] + 64'd131072) >> 18);
            p.x = blend_coord(s.x, w);
            p.y = blend_coord(s.y, w);
            p.last = (i == n - 1);
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    function automatic logic [255:0] rand_seg(input int kind);
        logic [255:0] s;
        for (int k = 0; k < 8; k++) begin
            case (kind)
                0: s[32*k +: 32] = $urandom;
                1: s[32*k +: 32] = 32'($signed($urandom_range(0, 2000000)) - 1000000);
                default: s[32*k +: 32] = ($urandom_range(0, 1)) ?
                                         32'h7fff0000 + $urandom_range(0, 65535) :
                                         32'h80000000 + $urandom_range(0, 65535);
            endcase
        end
        return s;
    endfunction

    // sender: one transaction, random gaps unless quiet; valid stays high
    // after acceptance so that back-to-back transactions need no gap
    task automatic send_segment(input logic [255:0] seg, input bit has_known = 1'b0,
                                input t_point known = '0);
        int first_idx;
        while (!tx_quiet && $urandom_range(0, 99) < 7) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= seg;
        do @(posedge i_clk); while (!o_s_axis_tready);
        // accepted at this edge: model it before the pipe can answer
        first_idx = expected_points.size();
        predict_curve(seg);
        if (has_known)
            expected_points[first_idx] = known;
        idle_cycles = 0;
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] v);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        count_reg = v;
    endtask

    // receiver ready: random stalls unless quiet, optional hold-off
    always @(posedge i_clk) begin
        if (rx_hold)
            i_m_axis_tready <= 1'b0;
        else if (rx_quiet)
            i_m_axis_tready <= 1'b1;
        else
            i_m_axis_tready <= ($urandom_range(0, 99) >= 7);
    end

    // result checker, compares each point transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            idle_cycles = 0;
            if (expected_points.size() == 0) begin
                $error("point with nothing expected: x=%h y=%h", o_m_axis_tdata[31:0],
                       o_m_axis_tdata[63:32]);
                n_fail++;
            end else begin
                e = expected_points.pop_front();
                if (o_m_axis_tdata[31:0] !== e.x) begin
                    $error("point_x exp %h got %h", e.x, o_m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (o_m_axis_tdata[63:32] !== e.y) begin
                    $error("point_y exp %h got %h", e.y, o_m_axis_tdata[63:32]);
                    n_fail++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $error("last_point exp %b got %b", e.last, o_m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    t_seg_row rows[$];

    task automatic add_row(input logic [255:0] s, input bit known);
        t_seg_row r;
        r.seg = s;
        r.has_known = known;
        r.known = '{x: s[31:0], y: s[63:32], last: 1'b0};
        rows.insert(rows.size(), r);
    endtask

    initial begin
        logic [6:0] counts[6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset count, then edge counts
        add_row('0, 1'b1);
        add_row({8{32'h7fffffff}}, 1'b1);
        add_row({8{32'h80000000}}, 1'b1);
        // wild control points at the extremes of the coordinate range
        add_row({32'h0, 32'h0, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0}, 1'b1);
        add_row({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000}, 1'b1);
        add_row({8{32'hffffffff}}, 1'b1);
        add_row({8{32'h55555555}}, 1'b1);
        add_row({8{32'haaaaaaaa}}, 1'b1);
        // first point of each row is checked against its typed start point,
        // the rest against the predictor
        foreach (rows[i])
            send_segment(rows[i].seg, rows[i].has_known, rows[i].known);
        wait_drained();
        // count extremes: too small, minimum, maximum, too large
        foreach (counts[c]) begin
            write_count(counts[c]);
            send_segment({32'h00010000, 32'hfff00000, 32'h7fffffff, 32'h00001000,
                          32'h80000000, 32'h00400000, 32'h12345678, 32'h87654321});
            send_segment(rand_seg(0));
            wait_drained();
        end

        // receiver holds off while the sender keeps offering
        write_count(7'd8);
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            repeat (6) send_segment(rand_seg(1));
        join
        wait_drained();

        // random part, several count settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_count(7'd16);
                1: write_count(7'($urandom_range(2, 12)));
                2: write_count(7'd2);
                3: write_count(7'($urandom_range(0, 127)));
                4: write_count(7'd3);
                default: write_count(7'($urandom_range(2, 20)));
            endcase
            rx_quiet = (ph == 2);
            tx_quiet = (ph == 2);
            for (int i = 0; i < RANDOM_SEGS / 6; i++)
                send_segment(rand_seg($urandom_range(0, 99) < 60 ? 0 :
                                      ($urandom_range(0, 1) ? 1 : 2)));
            // sender pauses until everything has come back
            wait_drained();
        end
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;

        wait_drained();
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
